@@ rtl/core/indexed_stack_with_sort_top_macros.svh @@
// assertion macros for the indexed stack with sort
// used by the checker module; needs clk and rst_n in scope
`ifndef INDEXED_STACK_WITH_SORT_TOP_MACROS_SVH
`define INDEXED_STACK_WITH_SORT_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define ISWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isws check failed");

// next-cycle implication, held off during reset
`define ISWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isws check failed");

`endif

@@ rtl/core/isws_pkg.sv @@
// package for the indexed stack with sort: sizes, operation codes, state type
// no dependencies
package isws_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_CLEAR = 3'd4,
        OP_SORT  = 3'd5
    } isws_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SORT_CARRY,
        S_SORT_CMP,
        S_SORT_RD,
        S_SORT_END
    } isws_state_t;

endpackage

@@ rtl/core/indexed_stack_with_sort_top.sv @@
// top level of the indexed stack with sort: control, count and element memory
// depends on isws_pkg
//
// channel   direction  beat marker          payload
// command   in         start && !busy       operation, operand_value, position
// result    out        done (one cycle)     read_value, element_count, error
//
// push, write, clear, sort of fewer than two elements and unused codes: the
//   result beat comes in the cycle after the command beat, busy stays low
// pop and read: the memory read is registered and the result beat comes from S_RESP, busy high
// sort of n elements: each compare waits on a read of the single read port, issued in S_SORT_CARRY
//   or S_SORT_RD, then S_SORT_CMP; each pass ends in S_SORT_END; busy is high until the result beat
// reset clears the count and the control state; the memory is not cleared
//   and needs no sweep since only entries below the count are ever read
// the receiver cannot stall, so each result beat lasts exactly one cycle
module indexed_stack_with_sort_top
    import isws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic [2:0]               operation,
    input  logic signed [DATA_W-1:0] operand_value,
    input  logic [POS_W-1:0]         position,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]         element_count,
    output logic                     error
);

    // element store, bottom of the stack at entry 0
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    isws_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         lim_reg, lim_next;     // length of the current sort pass
    logic [ADDR_W-1:0]        j_reg, j_next;         // lower entry of the pair in work
    logic signed [DATA_W-1:0] carry_reg, carry_next; // element bubbling towards the top
    logic                     done_reg, done_next;
    logic                     error_reg, error_next;

    logic                     accept;
    logic                     pos_out;    // position at or beyond the count
    logic [CNT_W-1:0]         pos_addr;   // entry addressed by position
    logic signed [DATA_W-1:0] rd_signed;

    assign accept    = start && (state_reg == S_IDLE);
    assign pos_out   = ({{CNT_W{1'b0}}, position} >= {{POS_W{1'b0}}, count_reg});
    assign pos_addr  = count_reg - CNT_W'(1) - CNT_W'(position);
    assign rd_signed = $signed(mem_rdata_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // next state, register updates and memory control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lim_next   = lim_reg;
        j_next     = j_reg;
        carry_next = carry_reg;
        done_next  = 1'b0;
        error_next = error_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    error_next = 1'b0;
                    case (isws_op_t'(operation))
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                error_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[ADDR_W-1:0];
                                mem_wdata  = operand_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next  = 1'b1;
                                error_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_RESP;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_out)
                            begin
                                done_next  = 1'b1;
                                error_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_addr[ADDR_W-1:0];
                                state_next = S_RESP;
                            end
                        end
                        OP_WRITE:
                        begin
                            done_next = 1'b1;
                            if (pos_out)
                            begin
                                error_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_addr[ADDR_W-1:0];
                                mem_wdata = operand_value;
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        OP_SORT:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                lim_next   = count_reg;
                                j_next     = '0;
                                state_next = S_SORT_CARRY;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            S_SORT_CARRY:
            begin
                // entry 0 arrives, fetch its upper neighbour
                carry_next = rd_signed;
                mem_re     = 1'b1;
                mem_raddr  = j_reg + ADDR_W'(1);
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                // the smaller value travels upwards, the larger settles at j
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                if (carry_reg < rd_signed)
                begin
                    mem_wdata = mem_rdata_reg;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = rd_signed;
                end
                j_next = j_reg + ADDR_W'(1);
                if ((CNT_W'(j_reg) + CNT_W'(2)) < lim_reg)
                begin
                    state_next = S_SORT_RD;
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end
            S_SORT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = j_reg + ADDR_W'(1);
                state_next = S_SORT_CMP;
            end
            S_SORT_END:
            begin
                // park the pass minimum at the top of the pass range
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(lim_reg - CNT_W'(1));
                mem_wdata = carry_reg;
                lim_next  = lim_reg - CNT_W'(1);
                j_next    = '0;
                if ((lim_reg - CNT_W'(1)) >= CNT_W'(2))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    state_next = S_SORT_CARRY;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result and handshake outputs
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        done          = done_reg || (state_reg == S_RESP);
        read_value    = (state_reg == S_RESP) ? rd_signed : '0;
        element_count = count_reg;
        error         = error_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lim_reg   <= '0;
            j_reg     <= '0;
            done_reg  <= 1'b0;
            error_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lim_reg   <= lim_next;
            j_reg     <= j_next;
            done_reg  <= done_next;
            error_reg <= error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

endmodule

@@ rtl/core/isws_checker.sv @@
// port-level checker for the indexed stack with sort, bound to the top level
// depends on isws_pkg and indexed_stack_with_sort_top_macros.svh
`include "indexed_stack_with_sort_top_macros.svh"

module isws_checker
    import isws_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic [2:0]               operation,
    input logic signed [DATA_W-1:0] operand_value,
    input logic [POS_W-1:0]         position,
    input logic signed [DATA_W-1:0] read_value,
    input logic [CNT_W-1:0]         element_count,
    input logic                     error
);

    logic beat_in;
    assign beat_in = start && !busy;

    `ISWS_ASSERT_NOW(a_count_range, 1'b1, element_count <= CNT_W'(DEPTH))

    `ISWS_ASSERT_NOW(a_error_zero, done && error, read_value == '0)

    `ISWS_ASSERT_NEXT(a_pop_empty, beat_in && (operation == OP_POP) && (element_count == '0), done && error)

    `ISWS_ASSERT_NEXT(a_clear, beat_in && (operation == OP_CLEAR), done && !error && (element_count == '0))

    `ISWS_ASSERT_NEXT(a_push_room, beat_in && (operation == OP_PUSH) && (element_count != CNT_W'(DEPTH)), done && !error && (element_count == $past(element_count) + CNT_W'(1)))

endmodule

bind indexed_stack_with_sort_top isws_checker u_isws_checker (.*);

@@ dv/tb_indexed_stack_with_sort_top.sv @@
// testbench for indexed_stack_with_sort_top: directed and random stack commands
// checked beat by beat against a shadow stack; depends on isws_pkg and the rtl
module tb_indexed_stack_with_sort_top
    import isws_pkg::*;
();

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    // codes beyond sort: the block must treat them as no-ops
    localparam logic [2:0]  OP_SPARE_A    = 3'd6;
    localparam logic [2:0]  OP_SPARE_B    = 3'd7;
    // sorts in the random part stay small, the cost grows with count squared
    localparam int          SORT_MAX_FILL = 40;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
        logic                     err;
    } stack_reply_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     done;
    logic [2:0]               operation = '0;
    logic signed [DATA_W-1:0] operand_value = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         element_count;
    logic                     error;

    // shadow of the block: bottom of the stack at entry 0
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_count = 0;

    stack_reply_t             pending_replies [$];
    int                       idle_pct = 0;
    int                       error_total = 0;
    int unsigned              cycle_count = 0;

    indexed_stack_with_sort_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .operation     (operation),
        .operand_value (operand_value),
        .position      (position),
        .read_value    (read_value),
        .element_count (element_count),
        .error         (error)
    );

    always #CLK_HALF clk = ~clk;

    // watchdog: a hung handshake or a missing result beat ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // apply one command to the shadow stack and work out its result beat
    function automatic stack_reply_t apply_stack_op(
        input logic [2:0]               op,
        input logic signed [DATA_W-1:0] val,
        input logic [POS_W-1:0]         pos
    );
        stack_reply_t             r;
        int                       i;
        int                       j;
        logic signed [DATA_W-1:0] tmp;
        r.value = '0;
        r.err   = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (shadow_count >= DEPTH)
                    r.err = 1'b1;
                else
                begin
                    shadow_store[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_POP:
            begin
                if (shadow_count == 0)
                    r.err = 1'b1;
                else
                begin
                    shadow_count--;
                    r.value = shadow_store[shadow_count];
                end
            end
            OP_READ:
            begin
                if (int'(pos) >= shadow_count)
                    r.err = 1'b1;
                else
                    r.value = shadow_store[shadow_count - 1 - int'(pos)];
            end
            OP_WRITE:
            begin
                if (int'(pos) >= shadow_count)
                    r.err = 1'b1;
                else
                    shadow_store[shadow_count - 1 - int'(pos)] = val;
            end
            OP_CLEAR:
                shadow_count = 0;
            OP_SORT:
            begin
                // largest sinks to the bottom, smallest ends on top
                for (i = 0; i + 1 < shadow_count; i++)
                begin
                    for (j = 0; j + 1 < shadow_count - i; j++)
                    begin
                        if (shadow_store[j] < shadow_store[j + 1])
                        begin
                            tmp                 = shadow_store[j];
                            shadow_store[j]     = shadow_store[j + 1];
                            shadow_store[j + 1] = tmp;
                        end
                    end
                end
            end
            default:
                ;
        endcase
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // every result beat is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        stack_reply_t exp_reply;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing outstanding: read_value %0d count %0d error %0b",
                       read_value, element_count, error);
                error_total++;
            end
            else
            begin
                exp_reply = pending_replies.pop_front();
                if (read_value !== exp_reply.value)
                begin
                    $error("read_value mismatch: expected %0d, actual %0d",
                           exp_reply.value, read_value);
                    error_total++;
                end
                if (element_count !== exp_reply.count)
                begin
                    $error("element_count mismatch: expected %0d, actual %0d",
                           exp_reply.count, element_count);
                    error_total++;
                end
                if (error !== exp_reply.err)
                begin
                    $error("error mismatch: expected %0b, actual %0b",
                           exp_reply.err, error);
                    error_total++;
                end
            end
        end
    end

    // drive one command beat and hold it until the block takes it
    // start is left high so back-to-back beats need no extra assignment
    task automatic send_cmd(
        input logic [2:0]               op,
        input logic signed [DATA_W-1:0] val,
        input logic [POS_W-1:0]         pos
    );
        start         <= 1'b1;
        operation     <= op;
        operand_value <= val;
        position      <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_replies.push_back(apply_stack_op(op, val, pos));
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // sender goes quiet until every outstanding result beat is back
    task automatic wait_until_settled();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // values biased to the extremes and to small numbers, so sorts see ties
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return {1'b1, {(DATA_W-1){1'b0}}};
        else if (r < 6)
            return {1'b0, {(DATA_W-1){1'b1}}};
        else if (r < 8)
            return '0;
        else if (r < 10)
            return '1;
        else if (r < 40)
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
        else
            return $urandom;
    endfunction

    // mostly a valid index, sometimes the first one past the top, sometimes anything
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (shadow_count == 0 || r < 15)
            return POS_W'($urandom_range(0, 255));
        else if (r < 27 && shadow_count <= 255)
            return POS_W'(shadow_count);
        else
            return POS_W'($urandom_range(0, shadow_count - 1));
    endfunction

    // empty stack: pop, read and write must all flag, the rest must not
    task automatic test_empty_stack();
        idle_pct = 0;
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_READ, '0, '0);
        send_cmd(OP_WRITE, 32'sd77, '0);
        send_cmd(OP_READ, '0, 8'd255);
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_CLEAR, '0, '0);
        send_cmd(OP_SPARE_A, '1, 8'd255);
        send_cmd(OP_SPARE_B, '1, '0);
        wait_until_settled();
    endtask

    // field extremes, each operation, index boundary, small sorts
    task automatic test_basic_ops();
        send_cmd(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}}, '0);
        send_cmd(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}}, 8'd255);
        send_cmd(OP_PUSH, '0, '0);
        send_cmd(OP_PUSH, '1, '0);
        send_cmd(OP_PUSH, 32'sd1, '0);
        send_cmd(OP_READ, '0, 8'd0);
        send_cmd(OP_READ, '0, 8'd4);
        send_cmd(OP_READ, '0, 8'd5);
        send_cmd(OP_WRITE, 32'sd12345, 8'd4);
        send_cmd(OP_WRITE, '1, 8'd5);
        send_cmd(OP_READ, '0, 8'd4);
        send_cmd(OP_PUSH, '1, '0);
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_READ, '0, 8'd0);
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_SPARE_A, '0, '0);
        send_cmd(OP_CLEAR, '0, '0);
        send_cmd(OP_PUSH, 32'sd5, '0);
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_POP, '0, '0);
        wait_until_settled();
    endtask

    // fill to the top, push past it, touch the deepest index, one full sort
    task automatic test_full_stack();
        idle_pct = 20;
        send_cmd(OP_CLEAR, '0, '0);
        repeat (DEPTH) send_cmd(OP_PUSH, pick_value(), pick_position());
        send_cmd(OP_PUSH, 32'sd99, '0);
        send_cmd(OP_READ, '0, 8'd255);
        send_cmd(OP_WRITE, {1'b1, {(DATA_W-1){1'b0}}}, 8'd255);
        send_cmd(OP_READ, '0, 8'd255);
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_READ, '0, 8'd0);
        send_cmd(OP_READ, '0, 8'd255);
        repeat (6) send_cmd(OP_POP, '0, '0);
        send_cmd(OP_CLEAR, '0, '0);
        send_cmd(OP_POP, '0, '0);
        wait_until_settled();
    endtask

    // random command mix; pushes outweigh pops so the stack grows,
    // clears pull it back, and push bursts now and then drive it to full
    task automatic test_random_traffic(input int n_items, input int pct);
        int         k;
        int         r;
        int         burst;
        logic [2:0] op;
        idle_pct = pct;
        k = 0;
        while (k < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 1 && shadow_count < 128)
            begin
                burst = $urandom_range(40, 180);
                repeat (burst) send_cmd(OP_PUSH, pick_value(), pick_position());
                k += burst;
            end
            else
            begin
                if (r < 36)
                    op = OP_PUSH;
                else if (r < 55)
                    op = OP_POP;
                else if (r < 70)
                    op = OP_READ;
                else if (r < 84)
                    op = OP_WRITE;
                else if (r < 87)
                    op = OP_CLEAR;
                else if (r < 90)
                    op = (shadow_count <= SORT_MAX_FILL) ? OP_SORT : OP_READ;
                else if (r < 93)
                    op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                else
                    op = 3'($urandom_range(0, 7));
                // a sort on a deep stack would dominate the run time
                if (op == OP_SORT && shadow_count > SORT_MAX_FILL)
                    op = OP_READ;
                send_cmd(op, pick_value(), pick_position());
                k++;
            end
            if ($urandom_range(0, 199) == 0)
                wait_until_settled();
        end
        wait_until_settled();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_basic_ops();
        test_full_stack();
        // phases: steady sender, then heavy and moderate sender gaps, then steady
        test_random_traffic(325, 0);
        test_random_traffic(325, 45);
        test_random_traffic(325, 30);
        test_random_traffic(325, 0);
        wait_until_settled();

        if (error_total == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
